// File: rtl/lbc_pkg.sv
package lbc_pkg;

	// Field widths of one request and one result.
	localparam int LBC_ID_W     = 16;
	localparam int LBC_OFF_W    = 4;
	localparam int LBC_BYTE_W   = 8;
	localparam int LBC_ACTION_W = 2;
	localparam int LBC_INDEX_W  = 4;

	// A lookup never returns more than this many bytes.
	localparam int LBC_MAX_RESULTS = 16;

	// Depth of the request queue between the front and the back.
	localparam int LBC_QDEPTH = 2;
	localparam int LBC_QPTR_W = 1;
	localparam int LBC_QCNT_W = 2;

	// Value of a byte that has never been written or has been invalidated.
	localparam logic [LBC_BYTE_W-1:0] LBC_EMPTY_BYTE = 8'hFF;

	// Action codes carried by a request.
	localparam logic [LBC_ACTION_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [LBC_ACTION_W-1:0] ACT_FILL   = 2'd1;
	localparam logic [LBC_ACTION_W-1:0] ACT_INVAL  = 2'd2;

	// Classification made by the front.
	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_LOOKUP,
		KIND_ALLOC,
		KIND_CONT,
		KIND_INVAL
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [LBC_ID_W-1:0]    block_id;
		logic [LBC_OFF_W-1:0]   byte_offset;
		logic [LBC_BYTE_W-1:0]  fill_byte;
	} cmd_t;

	// Sequencer states of the back.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MATCH,
		ST_DECIDE,
		ST_SCAN,
		ST_ALLOC,
		ST_SWEEP,
		ST_STREAM,
		ST_RESP
	} st_t;

endpackage

// File: rtl/lbc_front.sv
module lbc_front #(
	parameter int BLOCK_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lbc_pkg::LBC_ACTION_W-1:0] action,
	input  logic [lbc_pkg::LBC_ID_W-1:0]     block_id,
	input  logic [lbc_pkg::LBC_OFF_W-1:0]    byte_offset,
	input  logic [lbc_pkg::LBC_BYTE_W-1:0]   fill_byte,
	input  logic                          clearing,
	output logic                          q_valid,
	output lbc_pkg::cmd_t                 q_cmd,
	input  logic                          q_pop
);
	import lbc_pkg::*;

	cmd_t                  slot_q [LBC_QDEPTH];
	logic [LBC_QPTR_W-1:0] wr_ptr_q;
	logic [LBC_QPTR_W-1:0] rd_ptr_q;
	logic [LBC_QCNT_W-1:0] count_q;
	cmd_t                  cmd_w;
	logic                  push;

	// Classify the request. A fill at an offset beyond the block can never
	// write anything, so it is turned into a plain miss here.
	always_comb begin
		cmd_w.block_id    = block_id;
		cmd_w.byte_offset = byte_offset;
		cmd_w.fill_byte   = fill_byte;
		case (action)
			ACT_LOOKUP: begin
				cmd_w.kind = KIND_LOOKUP;
			end
			ACT_FILL: begin
				if (byte_offset == '0) begin
					cmd_w.kind = KIND_ALLOC;
				end else if (32'(byte_offset) < BLOCK_BYTES) begin
					cmd_w.kind = KIND_CONT;
				end else begin
					cmd_w.kind = KIND_NOP;
				end
			end
			ACT_INVAL: begin
				cmd_w.kind = KIND_INVAL;
			end
			default: begin
				cmd_w.kind = KIND_NOP;
			end
		endcase
	end

	assign in_stall = (count_q == LBC_QCNT_W'(LBC_QDEPTH)) || clearing;
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_cmd    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_w;
		end
	end

endmodule

// File: rtl/lbc_back.sv
module lbc_back #(
	parameter int ENTRIES     = 16,
	parameter int BLOCK_BYTES = 16,
	parameter int TAG_BITS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  lbc_pkg::cmd_t                   q_cmd,
	output logic                            q_pop,
	output logic                            clearing,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic [lbc_pkg::LBC_BYTE_W-1:0]  out_byte,
	output logic [lbc_pkg::LBC_INDEX_W-1:0] entry_index,
	output logic                            last
);
	import lbc_pkg::*;

	localparam int NBYTES = (BLOCK_BYTES < LBC_MAX_RESULTS) ? BLOCK_BYTES : LBC_MAX_RESULTS;
	localparam int TOTAL  = ENTRIES * BLOCK_BYTES;
	localparam int IDXW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MEMAW  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int CNTW   = $clog2(BLOCK_BYTES + 1);
	localparam int SCW    = $clog2(ENTRIES + 1);

	st_t                   state_q, state_d;
	cmd_t                  cmd_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [ENTRIES-1:0]    match_q;
	logic [TAG_BITS-1:0]   tag_q [ENTRIES];
	logic [31:0]           stamps_q [ENTRIES];
	logic [LBC_BYTE_W-1:0] bytes_q [TOTAL];
	logic [31:0]           clock_q;
	logic [IDXW-1:0]       fill_target_q;
	logic [IDXW-1:0]       pick_q;
	logic                  res_hit_q;
	logic [IDXW-1:0]       res_idx_q;
	logic [CNTW-1:0]       cnt_q;
	logic [MEMAW-1:0]      clr_addr_q;
	logic [SCW-1:0]        scan_cnt_q;
	logic                  cmp_v_q;
	logic [IDXW-1:0]       cmp_idx_q;
	logic [31:0]           stamp_rd_q;
	logic [31:0]           best_q;
	logic [IDXW-1:0]       best_idx_q;
	logic                  rd_pend_q;
	logic                  rd_last_q;
	logic [LBC_BYTE_W-1:0] rdata_q;
	logic                  out_valid_q;
	logic                  hit_q;
	logic [LBC_BYTE_W-1:0] byte_q;
	logic [IDXW-1:0]       idx_q;
	logic                  last_q;

	logic [TAG_BITS-1:0]   tag_w;
	logic                  any_match;
	logic [IDXW-1:0]       match_idx;
	logic                  any_free;
	logic [IDXW-1:0]       free_idx;
	logic                  ft_match;
	logic                  slot_free;
	logic                  consume;
	logic                  issue;
	logic                  load_out;
	logic                  better;
	logic                  scan_done;
	logic                  mem_we;
	logic [MEMAW-1:0]      mem_waddr;
	logic [LBC_BYTE_W-1:0] mem_wdata;
	logic                  mem_re;
	logic [MEMAW-1:0]      mem_raddr;
	logic                  st_we;
	logic [IDXW-1:0]       st_waddr;
	logic [31:0]           st_wdata;
	logic                  st_re;

	function automatic logic [MEMAW-1:0] row_base(input logic [IDXW-1:0] idx);
		row_base = MEMAW'(32'(idx) * BLOCK_BYTES);
	endfunction

	assign tag_w    = TAG_BITS'(cmd_q.block_id);
	assign ft_match = match_q[fill_target_q];
	assign clearing = (state_q == ST_CLEAR);

	// First matching entry and first empty entry.
	always_comb begin
		match_idx = '0;
		free_idx  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				match_idx = IDXW'(i);
			end
			if (!valid_q[i]) begin
				free_idx = IDXW'(i);
			end
		end
		any_match = |match_q;
		any_free  = ~&valid_q;
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign consume   = rd_pend_q && slot_free;
	assign issue     = (cnt_q < CNTW'(NBYTES)) && (!rd_pend_q || consume);
	assign load_out  = ((state_q == ST_RESP) && slot_free) ||
	                   ((state_q == ST_STREAM) && consume);
	assign better    = (cmp_idx_q == '0) || (stamp_rd_q < best_q);
	assign scan_done = cmp_v_q && (cmp_idx_q == IDXW'(ENTRIES - 1));
	assign st_wdata  = clock_q + 32'd1;

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = row_base(pick_q) + MEMAW'(cnt_q);
		mem_wdata = LBC_EMPTY_BYTE;
		mem_re    = 1'b0;
		mem_raddr = row_base(pick_q) + MEMAW'(cnt_q);
		st_we     = 1'b0;
		st_waddr  = pick_q;
		st_re     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				if (clr_addr_q == MEMAW'(TOTAL - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				case (cmd_q.kind)
					KIND_LOOKUP: begin
						if (any_match) begin
							st_we    = 1'b1;
							st_waddr = match_idx;
							state_d  = ST_STREAM;
						end else begin
							state_d = ST_RESP;
						end
					end
					KIND_ALLOC: begin
						state_d = any_free ? ST_ALLOC : ST_SCAN;
					end
					KIND_CONT: begin
						if (ft_match) begin
							mem_we    = 1'b1;
							mem_waddr = row_base(fill_target_q) + MEMAW'(cmd_q.byte_offset);
							mem_wdata = cmd_q.fill_byte;
						end
						state_d = ST_RESP;
					end
					KIND_INVAL: begin
						state_d = any_match ? ST_SWEEP : ST_RESP;
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_SCAN: begin
				st_re = (scan_cnt_q < SCW'(ENTRIES));
				if (scan_done) begin
					state_d = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				mem_we    = 1'b1;
				mem_waddr = row_base(pick_q);
				mem_wdata = cmd_q.fill_byte;
				st_we     = 1'b1;
				state_d   = ST_RESP;
			end
			ST_SWEEP: begin
				mem_we = 1'b1;
				if (cnt_q == CNTW'(BLOCK_BYTES - 1)) begin
					state_d = ST_RESP;
				end
			end
			ST_STREAM: begin
				mem_re = issue;
				if (consume && rd_last_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			valid_q       <= '0;
			fill_target_q <= '0;
			clock_q       <= '0;
			out_valid_q   <= 1'b0;
			rd_pend_q     <= 1'b0;
			cmp_v_q       <= 1'b0;
			clr_addr_q    <= '0;
			cnt_q         <= '0;
			scan_cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				ST_DECIDE: begin
					cnt_q      <= '0;
					rd_pend_q  <= 1'b0;
					scan_cnt_q <= '0;
					cmp_v_q    <= 1'b0;
					if ((cmd_q.kind == KIND_LOOKUP) && any_match) begin
						clock_q <= clock_q + 32'd1;
					end
					if ((cmd_q.kind == KIND_INVAL) && any_match) begin
						valid_q[match_idx] <= 1'b0;
					end
				end
				ST_SCAN: begin
					cmp_v_q <= st_re;
					if (st_re) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				ST_ALLOC: begin
					valid_q[pick_q] <= 1'b1;
					fill_target_q   <= pick_q;
					clock_q         <= clock_q + 32'd1;
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ST_STREAM: begin
					if (issue) begin
						rd_pend_q <= 1'b1;
						cnt_q     <= cnt_q + 1'b1;
					end else if (consume) begin
						rd_pend_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && q_valid) begin
			cmd_q <= q_cmd;
		end
		if (state_q == ST_MATCH) begin
			for (int i = 0; i < ENTRIES; i++) begin
				match_q[i] <= valid_q[i] && (tag_q[i] == tag_w);
			end
		end
		case (state_q)
			ST_DECIDE: begin
				// A continuation that lands and every miss settle their result here.
				res_hit_q <= (cmd_q.kind == KIND_CONT) && ft_match;
				res_idx_q <= ((cmd_q.kind == KIND_CONT) && ft_match) ? fill_target_q : '0;
				case (cmd_q.kind)
					KIND_LOOKUP: begin
						pick_q <= match_idx;
					end
					KIND_ALLOC: begin
						pick_q <= free_idx;
					end
					KIND_INVAL: begin
						if (any_match) begin
							pick_q           <= match_idx;
							tag_q[match_idx] <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				cmp_idx_q <= scan_cnt_q[IDXW-1:0];
				if (cmp_v_q) begin
					if (better) begin
						best_q     <= stamp_rd_q;
						best_idx_q <= cmp_idx_q;
					end
					if (scan_done) begin
						pick_q <= better ? cmp_idx_q : best_idx_q;
					end
				end
			end
			ST_ALLOC: begin
				tag_q[pick_q] <= tag_w;
				res_hit_q     <= 1'b1;
				res_idx_q     <= pick_q;
			end
			ST_SWEEP: begin
				res_hit_q <= 1'b1;
				res_idx_q <= pick_q;
			end
			ST_STREAM: begin
				if (issue) begin
					rd_last_q <= (cnt_q == CNTW'(NBYTES - 1));
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			if (state_q == ST_STREAM) begin
				hit_q  <= 1'b1;
				byte_q <= rdata_q;
				idx_q  <= pick_q;
				last_q <= rd_last_q;
			end else begin
				hit_q  <= res_hit_q;
				byte_q <= '0;
				idx_q  <= res_idx_q;
				last_q <= 1'b1;
			end
		end
	end

	// Block bytes and age stamps, each with one write and one registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bytes_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= bytes_q[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			stamps_q[st_waddr] <= st_wdata;
		end
		if (st_re) begin
			stamp_rd_q <= stamps_q[scan_cnt_q[IDXW-1:0]];
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign out_byte    = byte_q;
	assign entry_index = LBC_INDEX_W'(idx_q);
	assign last        = last_q;

endmodule

// File: rtl/lru_block_cache.sv
// From an idle block, a single result reaches the output register once the back has finished
// with its request; a lookup hit streams its bytes through the same register.
// A miss, a fill continuation or an invalidate miss is settled once the tags are compared; a
// fill into an empty entry also writes the entry, a fill that evicts first scans the stamps one per cycle,
// an invalidate hit clears its row and a lookup hit reads min(BLOCK_BYTES, 16) bytes.
// Reset: asynchronous, active low; afterwards a clearing pass fills the byte store.
module lru_block_cache #(
	parameter int ENTRIES     = 16,
	parameter int BLOCK_BYTES = 16,
	parameter int TAG_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lbc_pkg::LBC_ACTION_W-1:0]  action,
	input  logic [lbc_pkg::LBC_ID_W-1:0]      block_id,
	input  logic [lbc_pkg::LBC_OFF_W-1:0]     byte_offset,
	input  logic [lbc_pkg::LBC_BYTE_W-1:0]    fill_byte,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic [lbc_pkg::LBC_BYTE_W-1:0]    out_byte,
	output logic [lbc_pkg::LBC_INDEX_W-1:0]   entry_index,
	output logic                              last
);
	import lbc_pkg::*;

	// The front takes each request, works out what kind of action it is
	// and parks it in a two-deep queue. It stalls the input while that
	// queue is full and during the clearing pass that follows reset.
	logic clearing;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	lbc_front #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.block_id    (block_id),
		.byte_offset (byte_offset),
		.fill_byte   (fill_byte),
		.clearing    (clearing),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop)
	);

	// The back pulls one request at a time from the queue. It compares the
	// tag against every entry in one registered step, then carries out the
	// action: streaming a block, allocating an entry (searching for the
	// oldest stamp when the cache is full), writing a byte or clearing a row.
	// Results pass through an output register, so the queue keeps filling
	// while a result waits to be taken.
	lbc_back #(
		.ENTRIES     (ENTRIES),
		.BLOCK_BYTES (BLOCK_BYTES),
		.TAG_BITS    (TAG_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop),
		.clearing    (clearing),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.out_byte    (out_byte),
		.entry_index (entry_index),
		.last        (last)
	);

endmodule

// File: rtl/lbc_checker.sv
module lbc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [lbc_pkg::LBC_ACTION_W-1:0]  action,
	input logic [lbc_pkg::LBC_ID_W-1:0]      block_id,
	input logic [lbc_pkg::LBC_OFF_W-1:0]     byte_offset,
	input logic [lbc_pkg::LBC_BYTE_W-1:0]    fill_byte,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              hit,
	input logic [lbc_pkg::LBC_BYTE_W-1:0]    out_byte,
	input logic [lbc_pkg::LBC_INDEX_W-1:0]   entry_index,
	input logic                              last
);
	import lbc_pkg::*;

	// A stalled request stays put.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(action) && $stable(block_id) &&
		$stable(byte_offset) && $stable(fill_byte))
		else $error("stalled request changed");

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(out_byte) &&
		$stable(entry_index) && $stable(last))
		else $error("stalled result changed");

	// A result without a hit is a single, empty result.
	a_miss_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> last && (out_byte == '0) && (entry_index == '0))
		else $error("miss result is not a single empty result");

	// Only a lookup hit produces a run of several results.
	a_run_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> hit)
		else $error("non-final result without a hit");

	// The byte store is cleared after reset before any request is taken.
	a_reset_stall: assert property (@(posedge clk)
		!$past(arst_n) && arst_n |-> in_stall)
		else $error("request taken before clearing pass");

endmodule

bind lru_block_cache lbc_checker u_checker (.*);
